[hw/rtl/ptlru_pkg.sv]
// Shared types and constants for the peer table admission unit.
package ptlru_pkg;

    localparam int MAC_W      = 48;
    localparam int TS_W       = 48;
    localparam int MAGIC_W    = 32;
    localparam int NETID_W    = 64;
    localparam int ROLE_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [MAGIC_W-1:0] PAIR_WORD = 32'h5041_4952;
    localparam logic [SLOT_W-1:0]  NO_SLOT   = 3'd7;

    localparam logic [ROLE_W-1:0] ROLE_HELLO = 8'd0;
    localparam logic [ROLE_W-1:0] ROLE_REPLY = 8'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_IS_RECEIVER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_ID  = 2'd1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_FORWARD    = 3'd0,
        OUT_REGISTERED = 3'd1,
        OUT_FAILED     = 3'd2,
        OUT_LEARNED    = 3'd3,
        OUT_DROPPED    = 3'd4
    } outcome_t;

endpackage

[hw/rtl/peer_table_lru_admission_unit.sv]
// Peer table with least-recently-seen admission, table held in a synchronous memory.
//
//  Channel | Ports                                   | Transfer
//  --------+-----------------------------------------+--------------------------
//  input   | s_valid, s_ready, s_<field>             | one frame per transaction
//  result  | m_valid, m_ready, m_<field>             | one result per frame
//  config  | cfg_we, cfg_index, cfg_wdata            | one write per cycle
//
// Each result follows its frame through the scan, drain and decide states: the table
// memory has a single read port and is scanned one slot per cycle, followed by a drain state
// for the last read data and a decide state for the decision and write back.
// The input is ready again right after the decision, so a new frame is taken only once the last is through.
// Reset is synchronous and active low; it clears all used bits, so the table is empty.
// A result that is not taken holds the next frame in its decision cycle, and the input waits.
module peer_table_lru_admission_unit #(
    parameter int TABLE_SLOTS = 6,
    parameter int NETID_BYTES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [ptlru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptlru_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ptlru_pkg::MAC_W-1:0]         s_src_mac,
    input  logic                                s_frame_len_ok,
    input  logic [ptlru_pkg::MAGIC_W-1:0]       s_msg_magic,
    input  logic [ptlru_pkg::NETID_W-1:0]       s_msg_netid,
    input  logic [ptlru_pkg::ROLE_W-1:0]        s_msg_role,
    input  logic [ptlru_pkg::TS_W-1:0]          s_now_us,
    input  logic                                s_peer_add_ok,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ptlru_pkg::OUTCOME_W-1:0]     m_outcome,
    output logic [ptlru_pkg::SLOT_W-1:0]        m_slot_index,
    output logic                                m_evicted,
    output logic [ptlru_pkg::MAC_W-1:0]         m_evicted_mac,
    output logic                                m_table_changed
);
    import ptlru_pkg::*;

    localparam int ADDR_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int MATCH_W  = NETID_BYTES * 8;
    localparam int ENTRY_W  = MAC_W + TS_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    logic [ENTRY_W-1:0]     mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]     mem_wdata;

    state_t                 state_reg, state_next;
    logic [TABLE_SLOTS-1:0] used_reg, used_next;
    logic                   is_receiver_reg;
    logic [NETID_W-1:0]     network_id_reg;
    logic [MAC_W-1:0]       learned_mac_reg, learned_mac_next;

    logic [MAC_W-1:0]       mac_reg;
    logic                   len_ok_reg;
    logic [MAGIC_W-1:0]     magic_reg;
    logic [NETID_W-1:0]     netid_reg;
    logic [ROLE_W-1:0]      role_reg;
    logic [TS_W-1:0]        now_reg;
    logic                   add_ok_reg;

    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                   found_reg, found_next;
    logic [SLOT_W-1:0]      found_idx_reg, found_idx_next;
    logic                   have_old_reg, have_old_next;
    logic [SLOT_W-1:0]      old_idx_reg, old_idx_next;
    logic [TS_W-1:0]        old_ts_reg, old_ts_next;
    logic [MAC_W-1:0]       old_mac_reg, old_mac_next;

    logic                   m_valid_reg, m_valid_next;
    outcome_t               outcome_reg, outcome_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   evicted_reg, evicted_next;
    logic [MAC_W-1:0]       ev_mac_reg, ev_mac_next;
    logic                   changed_reg, changed_next;

    logic                   free_any;
    logic [SLOT_W-1:0]      free_idx;
    logic                   is_pair;
    logic [MAC_W-1:0]       rd_mac;
    logic [TS_W-1:0]        rd_ts;
    logic                   rd_used;
    logic [SLOT_W-1:0]      new_slot;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_outcome       = outcome_reg;
    assign m_slot_index    = slot_reg;
    assign m_evicted       = evicted_reg;
    assign m_evicted_mac   = ev_mac_reg;
    assign m_table_changed = changed_reg;

    assign rd_mac  = rd_data_reg[ENTRY_W-1:TS_W];
    assign rd_ts   = rd_data_reg[TS_W-1:0];
    assign rd_used = used_reg[rd_idx_reg[ADDR_W-1:0]];
    assign is_pair = len_ok_reg && (magic_reg == PAIR_WORD)
                     && (netid_reg[MATCH_W-1:0] == network_id_reg[MATCH_W-1:0]);
    assign new_slot = free_any ? free_idx : old_idx_reg;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN) begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_comb begin
        state_next       = state_reg;
        used_next        = used_reg;
        learned_mac_next = learned_mac_reg;
        idx_next         = idx_reg;
        rd_valid_next    = rd_valid_reg;
        rd_idx_next      = rd_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        have_old_next    = have_old_reg;
        old_idx_next     = old_idx_reg;
        old_ts_next      = old_ts_reg;
        old_mac_next     = old_mac_reg;
        m_valid_next     = m_valid_reg;
        outcome_next     = outcome_reg;
        slot_next        = slot_reg;
        evicted_next     = evicted_reg;
        ev_mac_next      = ev_mac_reg;
        changed_next     = changed_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = {mac_reg, now_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (rd_valid_reg && rd_used) begin
            if (rd_mac == mac_reg) begin
                found_next     = 1'b1;
                found_idx_next = rd_idx_reg;
            end
            if (!have_old_reg || (rd_ts < old_ts_reg)) begin
                have_old_next = 1'b1;
                old_idx_next  = rd_idx_reg;
                old_ts_next   = rd_ts;
                old_mac_next  = rd_mac;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next      = '0;
                    rd_valid_next = 1'b0;
                    found_next    = 1'b0;
                    have_old_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_valid_next = 1'b1;
                rd_idx_next   = idx_reg;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                rd_valid_next = 1'b0;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!m_valid_reg || m_ready) begin
                    outcome_next = OUT_FORWARD;
                    slot_next    = NO_SLOT;
                    evicted_next = 1'b0;
                    ev_mac_next  = '0;
                    changed_next = 1'b0;
                    if (is_pair) begin
                        if ((role_reg == ROLE_HELLO) && is_receiver_reg) begin
                            if (found_reg) begin
                                mem_we       = 1'b1;
                                mem_waddr    = found_idx_reg[ADDR_W-1:0];
                                outcome_next = OUT_REGISTERED;
                                slot_next    = found_idx_reg;
                            end else begin
                                if (!free_any) begin
                                    evicted_next = 1'b1;
                                    ev_mac_next  = old_mac_reg;
                                    used_next[old_idx_reg[ADDR_W-1:0]] = 1'b0;
                                end
                                if (add_ok_reg) begin
                                    mem_we       = 1'b1;
                                    mem_waddr    = new_slot[ADDR_W-1:0];
                                    used_next[new_slot[ADDR_W-1:0]] = 1'b1;
                                    outcome_next = OUT_REGISTERED;
                                    slot_next    = new_slot;
                                    changed_next = 1'b1;
                                end else begin
                                    outcome_next = OUT_FAILED;
                                end
                            end
                        end else if ((role_reg == ROLE_REPLY) && !is_receiver_reg) begin
                            learned_mac_next = mac_reg;
                            outcome_next     = OUT_LEARNED;
                        end else begin
                            outcome_next = OUT_DROPPED;
                        end
                    end else if (is_receiver_reg && found_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = found_idx_reg[ADDR_W-1:0];
                        slot_next = found_idx_reg;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            learned_mac_reg <= '0;
            is_receiver_reg <= 1'b0;
            network_id_reg  <= '0;
            m_valid_reg     <= 1'b0;
            rd_valid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            learned_mac_reg <= learned_mac_next;
            m_valid_reg     <= m_valid_next;
            rd_valid_reg    <= rd_valid_next;
            if (cfg_we) begin
                if (cfg_index == CFG_IS_RECEIVER) begin
                    is_receiver_reg <= cfg_wdata[0];
                end else if (cfg_index == CFG_NETWORK_ID) begin
                    network_id_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mac_reg    <= s_src_mac;
            len_ok_reg <= s_frame_len_ok;
            magic_reg  <= s_msg_magic;
            netid_reg  <= s_msg_netid;
            role_reg   <= s_msg_role;
            now_reg    <= s_now_us;
            add_ok_reg <= s_peer_add_ok;
        end
        idx_reg       <= idx_next;
        rd_idx_reg    <= rd_idx_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        have_old_reg  <= have_old_next;
        old_idx_reg   <= old_idx_next;
        old_ts_reg    <= old_ts_next;
        old_mac_reg   <= old_mac_next;
        outcome_reg   <= outcome_next;
        slot_reg      <= slot_next;
        evicted_reg   <= evicted_next;
        ev_mac_reg    <= ev_mac_next;
        changed_reg   <= changed_next;
    end

endmodule

[sim/peer_table_check.sv]
`timescale 1ns / 100ps
// Channel monitor that predicts each frame's classification and compares every result.
module peer_table_check #(
    parameter int TABLE_SLOTS = 6,
    parameter int NETID_BYTES = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ptlru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptlru_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [ptlru_pkg::MAC_W-1:0]        s_src_mac,
    input  logic                               s_frame_len_ok,
    input  logic [ptlru_pkg::MAGIC_W-1:0]      s_msg_magic,
    input  logic [ptlru_pkg::NETID_W-1:0]      s_msg_netid,
    input  logic [ptlru_pkg::ROLE_W-1:0]       s_msg_role,
    input  logic [ptlru_pkg::TS_W-1:0]         s_now_us,
    input  logic                               s_peer_add_ok,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [ptlru_pkg::OUTCOME_W-1:0]    m_outcome,
    input  logic [ptlru_pkg::SLOT_W-1:0]       m_slot_index,
    input  logic                               m_evicted,
    input  logic [ptlru_pkg::MAC_W-1:0]        m_evicted_mac,
    input  logic                               m_table_changed,
    output int                                 results_seen,
    output int                                 mismatch_count,
    output int                                 pending,
    output int                                 evictions
);
    import ptlru_pkg::*;

    typedef struct packed {
        logic [MAC_W-1:0]   src_mac;
        logic               len_ok;
        logic [MAGIC_W-1:0] magic;
        logic [NETID_W-1:0] netid;
        logic [ROLE_W-1:0]  role;
        logic [TS_W-1:0]    now_us;
        logic               add_ok;
    } frame_t;

    typedef struct packed {
        outcome_t           outcome;
        logic [SLOT_W-1:0]  slot_index;
        logic               evicted;
        logic [MAC_W-1:0]   evicted_mac;
        logic               table_changed;
    } frame_outcome_t;

    logic [MAC_W-1:0]   slot_mac [TABLE_SLOTS];
    logic               slot_used [TABLE_SLOTS];
    logic [TS_W-1:0]    slot_seen [TABLE_SLOTS];
    logic [MAC_W-1:0]   receiver_mac;
    logic               mode_rx;
    logic [NETID_W-1:0] our_netid;

    frame_outcome_t expected_outcomes[$];

    function automatic frame_outcome_t classify_frame(input frame_t f);
        frame_outcome_t r;
        logic [NETID_W-1:0] id_mask;
        logic [TS_W-1:0] oldest_stamp;
        int i, hit, open_slot, oldest, s;
        r.outcome = OUT_FORWARD;
        r.slot_index = NO_SLOT;
        r.evicted = 1'b0;
        r.evicted_mac = '0;
        r.table_changed = 1'b0;
        id_mask = (NETID_BYTES >= 8) ? '1 : (64'd1 << (8 * NETID_BYTES)) - 64'd1;
        hit = -1;
        open_slot = -1;
        oldest = 0;
        oldest_stamp = '1;
        for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_mac[i] == f.src_mac)
                hit = i;
            if (!slot_used[i])
                open_slot = i;
        end
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_seen[i] < oldest_stamp) begin
                oldest_stamp = slot_seen[i];
                oldest = i;
            end
        end

        if (f.len_ok && f.magic == PAIR_WORD && ((f.netid ^ our_netid) & id_mask) == '0) begin
            if (f.role == ROLE_HELLO && mode_rx) begin
                if (hit >= 0) begin
                    slot_seen[hit] = f.now_us;
                    r.outcome = OUT_REGISTERED;
                    r.slot_index = SLOT_W'(hit);
                end else begin
                    // With every slot taken, the least recently seen sender makes room.
                    if (open_slot >= 0) begin
                        s = open_slot;
                    end else begin
                        s = oldest;
                        r.evicted = 1'b1;
                        r.evicted_mac = slot_mac[s];
                        slot_used[s] = 1'b0;
                        evictions++;
                    end
                    if (f.add_ok) begin
                        slot_mac[s] = f.src_mac;
                        slot_used[s] = 1'b1;
                        slot_seen[s] = f.now_us;
                        r.outcome = OUT_REGISTERED;
                        r.slot_index = SLOT_W'(s);
                        r.table_changed = 1'b1;
                    end else begin
                        r.outcome = OUT_FAILED;
                    end
                end
            end else if (f.role == ROLE_REPLY && !mode_rx) begin
                receiver_mac = f.src_mac;
                r.outcome = OUT_LEARNED;
            end else begin
                r.outcome = OUT_DROPPED;
            end
        end else if (mode_rx && hit >= 0) begin
            slot_seen[hit] = f.now_us;
            r.slot_index = SLOT_W'(hit);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        frame_outcome_t want;
        frame_t f;
        int i;
        if (!aresetn) begin
            for (i = 0; i < TABLE_SLOTS; i++) begin
                slot_mac[i] = '0;
                slot_used[i] = 1'b0;
                slot_seen[i] = '0;
            end
            receiver_mac = '0;
            mode_rx = 1'b0;
            our_netid = '0;
            expected_outcomes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IS_RECEIVER: mode_rx = cfg_wdata[0];
                    CFG_NETWORK_ID:  our_netid = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result transaction with no frame outstanding: outcome %0d",
                           m_outcome);
                    mismatch_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("outcome", want.outcome, m_outcome);
                    check_field("slot_index", want.slot_index, m_slot_index);
                    check_field("evicted", want.evicted, m_evicted);
                    check_field("evicted_mac", want.evicted_mac, m_evicted_mac);
                    check_field("table_changed", want.table_changed, m_table_changed);
                    results_seen <= results_seen + 1;
                end
            end
            if (s_valid && s_ready) begin
                f.src_mac = s_src_mac;
                f.len_ok = s_frame_len_ok;
                f.magic = s_msg_magic;
                f.netid = s_msg_netid;
                f.role = s_msg_role;
                f.now_us = s_now_us;
                f.add_ok = s_peer_add_ok;
                expected_outcomes.push_back(classify_frame(f));
            end
        end
        pending = expected_outcomes.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the peer table admission unit: clock, reset, stimulus and verdict.
module tb_top;
    import ptlru_pkg::*;

    localparam int TABLE_SLOTS      = 6;
    localparam int NETID_BYTES      = 8;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 241;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int HOLD_OFF_AFTER   = 400;
    localparam int IDLE_LIMIT       = 4000;
    localparam int SETTLE_CYCLES    = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [MAC_W-1:0]      s_src_mac;
    logic                  s_frame_len_ok;
    logic [MAGIC_W-1:0]    s_msg_magic;
    logic [NETID_W-1:0]    s_msg_netid;
    logic [ROLE_W-1:0]     s_msg_role;
    logic [TS_W-1:0]       s_now_us;
    logic                  s_peer_add_ok;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUTCOME_W-1:0]  m_outcome;
    logic [SLOT_W-1:0]     m_slot_index;
    logic                  m_evicted;
    logic [MAC_W-1:0]      m_evicted_mac;
    logic                  m_table_changed;

    int results_seen;
    int mismatch_count;
    int pending;
    int evictions;

    int items_sent = 0;
    int phases = 0;
    int idle_cycles = 0;
    bit held_off = 1'b0;
    logic [NETID_W-1:0] net_cfg = '0;

    peer_table_lru_admission_unit #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .NETID_BYTES(NETID_BYTES)
    ) uut (.*);

    peer_table_check #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .NETID_BYTES(NETID_BYTES)
    ) u_check (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_frame(input logic [MAC_W-1:0] mac, input logic len_ok,
                              input logic [MAGIC_W-1:0] magic, input logic [NETID_W-1:0] netid,
                              input logic [ROLE_W-1:0] role, input logic [TS_W-1:0] stamp,
                              input logic add_ok);
        s_valid <= 1'b1;
        s_src_mac <= mac;
        s_frame_len_ok <= len_ok;
        s_msg_magic <= magic;
        s_msg_netid <= netid;
        s_msg_role <= role;
        s_now_us <= stamp;
        s_peer_add_ok <= add_ok;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic pair_frame(input logic [MAC_W-1:0] mac, input logic [ROLE_W-1:0] role,
                              input logic [TS_W-1:0] stamp, input logic add_ok);
        send_frame(mac, 1'b1, PAIR_WORD, net_cfg, role, stamp, add_ok);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic configure(input logic rx, input logic [NETID_W-1:0] nid);
        write_reg(CFG_IS_RECEIVER, CFG_DATA_W'(rx));
        write_reg(CFG_NETWORK_ID, nid);
        cfg_we <= 1'b0;
        net_cfg = nid;
        phases++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge aclk);
    endtask

    initial begin
        logic [MAC_W-1:0] pool [12];
        logic [MAC_W-1:0] mac;
        logic [TS_W-1:0] now_ts, stamp;
        logic [MAGIC_W-1:0] magic;
        logic [NETID_W-1:0] netid;
        logic [ROLE_W-1:0] role;
        logic len_ok, add_ok;
        int p, k, pool_n, ts_mode, burst_left, gap, kind;

        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_IS_RECEIVER;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_src_mac <= '0;
        s_frame_len_ok <= 1'b0;
        s_msg_magic <= '0;
        s_msg_netid <= '0;
        s_msg_role <= ROLE_HELLO;
        s_now_us <= '0;
        s_peer_add_ok <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Writes to unused register indexes must leave sender mode and network id zero intact.
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        cfg_we <= 1'b0;

        pair_frame('1, ROLE_REPLY, 48'd1, 1'b1);
        pair_frame(48'h0000_0000_0042, ROLE_HELLO, 48'd2, 1'b1);
        pair_frame(48'h0000_0000_0042, 8'hFF, 48'd3, 1'b1);
        send_frame(48'h1, 1'b0, PAIR_WORD, net_cfg, ROLE_REPLY, 48'd4, 1'b1);
        send_frame(48'h1, 1'b1, PAIR_WORD ^ 32'h1, net_cfg, ROLE_REPLY, 48'd5, 1'b1);
        send_frame(48'h1, 1'b1, PAIR_WORD, net_cfg ^ {1'b1, 63'd0}, ROLE_REPLY, 48'd6, 1'b1);
        drain();

        // Receiver mode: fill the table with ties on the oldest stamp, then force evictions.
        configure(1'b1, '1);
        pair_frame(48'h0, ROLE_HELLO, 48'd10, 1'b1);
        pair_frame(48'h0000_0000_1111, ROLE_HELLO, 48'd3, 1'b1);
        pair_frame(48'h0000_0000_2222, ROLE_HELLO, 48'd3, 1'b1);
        pair_frame(48'h0000_0000_3333, ROLE_HELLO, '1, 1'b1);
        pair_frame(48'h0000_0000_4444, ROLE_HELLO, 48'd7, 1'b1);
        pair_frame(48'h0000_0000_5555, ROLE_HELLO, 48'd3, 1'b1);
        pair_frame(48'h0000_0000_3333, ROLE_HELLO, 48'd20, 1'b0);
        pair_frame(48'h0000_0000_AAAA, ROLE_HELLO, 48'd50, 1'b1);
        pair_frame(48'h0000_0000_BBBB, ROLE_HELLO, 48'd60, 1'b0);
        pair_frame(48'h0000_0000_CCCC, ROLE_HELLO, 48'd70, 1'b1);
        pair_frame(48'h0000_0000_DDDD, ROLE_REPLY, 48'd80, 1'b1);
        pair_frame(48'h0000_0000_DDDD, 8'd2, 48'd90, 1'b1);
        send_frame(48'h0000_0000_5555, 1'b0, PAIR_WORD, net_cfg, ROLE_HELLO, 48'd100, 1'b1);
        send_frame(48'h0000_0000_EEEE, 1'b0, PAIR_WORD, net_cfg, ROLE_HELLO, 48'd105, 1'b1);
        pair_frame(48'h0000_0000_DDDD, ROLE_HELLO, 48'd110, 1'b1);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case (p)
                0: configure(1'b1, '0);
                1: configure(1'b0, '1);
                2: configure(1'b1, '1);
                default: configure($urandom_range(0, 3) != 0, rand64());
            endcase
            pool_n = (p % 3 == 2) ? 5 : $urandom_range(7, 12);
            for (k = 0; k < pool_n; k++)
                pool[k] = MAC_W'(rand64());
            if (p == 3) begin
                pool[0] = '0;
                pool[1] = '1;
            end
            ts_mode = $urandom_range(0, 2);
            now_ts = TS_W'($urandom_range(0, 1000));
            burst_left = 0;

            for (k = 0; k < FRAMES_PER_PHASE; k++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;

                case (ts_mode)
                    0: now_ts = now_ts + TS_W'($urandom_range(0, 3));
                    1: now_ts = TS_W'($urandom_range(0, 7));
                    default: now_ts = TS_W'(rand64());
                endcase
                stamp = now_ts;
                mac = pool[$urandom_range(0, pool_n - 1)];
                len_ok = 1'b1;
                magic = PAIR_WORD;
                netid = net_cfg;
                role = ROLE_HELLO;
                add_ok = ($urandom_range(0, 7) != 0);
                kind = $urandom_range(0, 99);

                if (kind >= 90) begin
                    mac = MAC_W'(rand64());
                    len_ok = 1'($urandom_range(0, 1));
                    magic = $urandom;
                    netid = rand64();
                    role = ROLE_W'($urandom);
                    stamp = TS_W'(rand64());
                    add_ok = 1'($urandom_range(0, 1));
                end else if (kind >= 70) begin
                    role = ROLE_W'($urandom_range(0, 1));
                    case ($urandom_range(0, 2))
                        0: len_ok = 1'b0;
                        1: magic = PAIR_WORD ^ (32'd1 << $urandom_range(0, 31));
                        default: netid = net_cfg ^ (64'd1 << $urandom_range(0, 63));
                    endcase
                end else if (kind >= 65) begin
                    role = ROLE_W'($urandom_range(2, 255));
                end else if (kind >= 55) begin
                    role = ROLE_REPLY;
                end

                send_frame(mac, len_ok, magic, netid, role, stamp, add_ok);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d frames under %0d register settings; %0d results compared, %0d evictions.",
                 items_sent, phases, results_seen, evictions);
        $display("Result channel held off once for %0d cycles while frames kept arriving.",
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int seg, mode, k;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held_off && items_sent >= HOLD_OFF_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                held_off = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(20, 200);
            for (k = 0; k < seg; k++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) >= 3);
                    2: m_ready <= ((k % 8) < 5);
                    default: m_ready <= ($urandom_range(0, 9) >= 8);
                endcase
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
